// File: sv/pbc_pkg.sv
// shared types, constants and helper functions for the polyline to bezier block
// used by every module of the block; depends on nothing
package pbc_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SCALE_W      = 16;
    localparam int FRAC_W       = 14;
    localparam int PROD_W       = DIFF_W + SCALE_W + 1;
    localparam int OFS_W        = PROD_W - FRAC_W;
    localparam int SUM_W        = OFS_W + 2;
    localparam int RND_BIAS     = 1 << (FRAC_W - 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5461;

    // chunking
    localparam int CHUNK_POINTS = 8;
    localparam int FILL_W       = $clog2(CHUNK_POINTS);

    // results per item and queue sizing
    localparam int STEP_W       = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    // stream widths
    localparam int TDATA_W      = 2 * COORD_W;
    localparam int TUSER_W      = 2;

    // saturation bounds
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [OFS_W-1:0]   ofs_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        diff_t y;
        diff_t x;
    } diff_pair_t;

    // kind of curve fragment a point produces
    typedef enum logic [1:0] {
        JOB_TWO  = 2'd0,   // two-point curve: a, a+o, b-o, b
        JOB_OPEN = 2'd1,   // curve opening: first anchor and its control
        JOB_MID  = 2'd2,   // inner point: p-o, p, p+o
        JOB_MIDC = 2'd3    // inner point that closes the chunk
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        point_t     p;
        point_t     q;
        diff_pair_t d1;
        diff_pair_t d2;
    } job_t;

    // which offset a result uses
    typedef enum logic [1:0] {
        OFS_NONE = 2'd0,
        OFS_ONE  = 2'd1,
        OFS_TWO  = 2'd2
    } ofs_sel_t;

    typedef struct packed {
        logic     use_q;
        ofs_sel_t ofs;
        logic     neg;
        logic     start;
        logic     stop;
        logic     fin;
    } step_t;

    // per-result recipe for each job kind
    function automatic step_t step_info(job_kind_t kind, logic [STEP_W-1:0] idx);
        step_t s;
        s = '0;
        case (kind)
            JOB_TWO:
            begin
                case (idx)
                    3'd0: s.start = 1'b1;
                    3'd1: s.ofs = OFS_ONE;
                    3'd2:
                    begin
                        s.use_q = 1'b1;
                        s.ofs   = OFS_ONE;
                        s.neg   = 1'b1;
                    end
                    default:
                    begin
                        s.use_q = 1'b1;
                        s.stop  = 1'b1;
                        s.fin   = 1'b1;
                    end
                endcase
            end
            JOB_OPEN:
            begin
                case (idx)
                    3'd0: s.start = 1'b1;
                    default:
                    begin
                        s.ofs = OFS_ONE;
                        s.fin = 1'b1;
                    end
                endcase
            end
            JOB_MID:
            begin
                case (idx)
                    3'd0:
                    begin
                        s.ofs = OFS_ONE;
                        s.neg = 1'b1;
                    end
                    3'd1: s.ofs = OFS_NONE;
                    default:
                    begin
                        s.ofs = OFS_ONE;
                        s.fin = 1'b1;
                    end
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0:
                    begin
                        s.ofs = OFS_ONE;
                        s.neg = 1'b1;
                    end
                    3'd1: s.ofs = OFS_NONE;
                    3'd2: s.ofs = OFS_ONE;
                    3'd3:
                    begin
                        s.use_q = 1'b1;
                        s.ofs   = OFS_TWO;
                        s.neg   = 1'b1;
                    end
                    default:
                    begin
                        s.use_q = 1'b1;
                        s.stop  = 1'b1;
                        s.fin   = 1'b1;
                    end
                endcase
            end
        endcase
        return s;
    endfunction

    // product scaled down by 2^14, rounded to nearest, ties away from zero
    function automatic ofs_t round_scale(prod_t prod);
        prod_t biased;
        prod_t shifted;
        biased  = prod + (prod[PROD_W-1] ? $signed(PROD_W'(RND_BIAS - 1))
                                         : $signed(PROD_W'(RND_BIAS)));
        shifted = biased >>> FRAC_W;
        return shifted[OFS_W-1:0];
    endfunction

    // clamp a wide sum to the coordinate range
    function automatic coord_t sat_coord(sum_t v);
        sum_t c;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        else
        begin
            c = v;
        end
        return c[COORD_W-1:0];
    endfunction

endpackage

// File: sv/pbc_front.sv
// front end: accepts polyline points, tracks chunk state and classifies each point
// into a curve job; depends on pbc_pkg
module pbc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pbc_pkg::point_t in_point,
    input  logic            in_last,
    input  logic            queue_full,
    output logic            push,
    output pbc_pkg::job_t   push_job
);
    import pbc_pkg::*;

    point_t              prev_reg;
    point_t              prev2_reg;
    point_t              tail_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                first_reg;

    logic                accept;
    logic                closes;
    logic                push_en;
    diff_pair_t          d_prev;
    diff_pair_t          d_prev2;
    diff_pair_t          d_tail;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign closes   = in_last || (fill_reg == FILL_W'(CHUNK_POINTS - 1));

    // differences against the held points
    always_comb
    begin
        d_prev.x  = DIFF_W'(in_point.x) - DIFF_W'(prev_reg.x);
        d_prev.y  = DIFF_W'(in_point.y) - DIFF_W'(prev_reg.y);
        d_prev2.x = DIFF_W'(in_point.x) - DIFF_W'(prev2_reg.x);
        d_prev2.y = DIFF_W'(in_point.y) - DIFF_W'(prev2_reg.y);
        d_tail.x  = DIFF_W'(tail_reg.x) - DIFF_W'(in_point.x);
        d_tail.y  = DIFF_W'(tail_reg.y) - DIFF_W'(in_point.y);
    end

    // classify the point by its place in the chunk
    always_comb
    begin
        push_en       = 1'b1;
        push_job.kind = JOB_TWO;
        push_job.p    = prev_reg;
        push_job.q    = in_point;
        push_job.d1   = d_prev;
        push_job.d2   = d_prev;
        if (fill_reg == '0)
        begin
            // lone final point pairs with the tail of the previous chunk
            push_en     = in_last && !first_reg;
            push_job.p  = in_point;
            push_job.q  = tail_reg;
            push_job.d1 = d_tail;
        end
        else if (fill_reg == FILL_W'(1))
        begin
            push_job.kind = closes ? JOB_TWO : JOB_OPEN;
        end
        else
        begin
            push_job.kind = closes ? JOB_MIDC : JOB_MID;
            push_job.d1   = d_prev2;
        end
    end

    assign push = accept && push_en;

    // chunk bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                fill_reg  <= '0;
                first_reg <= 1'b1;
            end
            else if (closes)
            begin
                fill_reg  <= '0;
                first_reg <= 1'b0;
            end
            else
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // point history
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev2_reg <= prev_reg;
            prev_reg  <= in_point;
            if (closes && !in_last)
            begin
                tail_reg <= in_point;
            end
        end
    end

endmodule

// File: sv/pbc_queue.sv
// short job queue between the front and back ends
// depends on pbc_pkg
module pbc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pbc_pkg::job_t push_job,
    output logic          full,
    output logic          pop_valid,
    input  logic          pop,
    output pbc_pkg::job_t pop_job
);
    import pbc_pkg::*;

    job_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_job   = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: sv/pbc_back.sv
// back end: scales tangents, rounds, and emits control points one per cycle
// when the output is not stalled; depends on pbc_pkg
module pbc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pbc_pkg::SCALE_W-1:0]     scale,
    input  logic                            job_valid,
    input  pbc_pkg::job_t                   job,
    output logic                            job_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pbc_pkg::point_t                 out_point,
    output logic                            out_start,
    output logic                            out_stop,
    output logic                            out_last
);
    import pbc_pkg::*;

    // multiply stage
    logic               s1_valid_reg;
    job_kind_t          s1_kind_reg;
    point_t             s1_p_reg;
    point_t             s1_q_reg;
    prod_t              s1_m1x_reg;
    prod_t              s1_m1y_reg;
    prod_t              s1_m2x_reg;
    prod_t              s1_m2y_reg;

    // emit stage
    logic               s2_valid_reg;
    job_kind_t          s2_kind_reg;
    point_t             s2_p_reg;
    point_t             s2_q_reg;
    ofs_t               s2_o1x_reg;
    ofs_t               s2_o1y_reg;
    ofs_t               s2_o2x_reg;
    ofs_t               s2_o2y_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    // output register
    logic               out_valid_reg;
    point_t             out_point_reg;
    logic               out_start_reg;
    logic               out_stop_reg;
    logic               out_last_reg;

    logic               out_load;
    logic               s2_done;
    logic               s2_take;
    logic               s1_take;
    step_t              info;
    point_t             base;
    ofs_t               ofs_x;
    ofs_t               ofs_y;
    sum_t               sum_x;
    sum_t               sum_y;
    logic signed [SCALE_W:0] scale_s;

    assign scale_s  = $signed({1'b0, scale});
    assign info     = step_info(s2_kind_reg, step_reg);
    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_done  = out_load && info.fin;
    assign s2_take  = !s2_valid_reg || s2_done;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign job_pop  = job_valid && s1_take;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_kind_reg <= job.kind;
            s1_p_reg    <= job.p;
            s1_q_reg    <= job.q;
            s1_m1x_reg  <= job.d1.x * scale_s;
            s1_m1y_reg  <= job.d1.y * scale_s;
            s1_m2x_reg  <= job.d2.x * scale_s;
            s1_m2y_reg  <= job.d2.y * scale_s;
        end
    end

    // step counter of the emit stage
    always_comb
    begin
        step_next = step_reg;
        if (s2_take)
        begin
            step_next = '0;
        end
        else if (out_load)
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // round the products on the way into the emit stage
    always_ff @(posedge clk)
    begin
        if (s2_take && s1_valid_reg)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_p_reg    <= s1_p_reg;
            s2_q_reg    <= s1_q_reg;
            s2_o1x_reg  <= round_scale(s1_m1x_reg);
            s2_o1y_reg  <= round_scale(s1_m1y_reg);
            s2_o2x_reg  <= round_scale(s1_m2x_reg);
            s2_o2y_reg  <= round_scale(s1_m2y_reg);
        end
    end

    // anchor plus or minus the chosen offset
    always_comb
    begin
        base = info.use_q ? s2_q_reg : s2_p_reg;
        case (info.ofs)
            OFS_ONE:
            begin
                ofs_x = s2_o1x_reg;
                ofs_y = s2_o1y_reg;
            end
            OFS_TWO:
            begin
                ofs_x = s2_o2x_reg;
                ofs_y = s2_o2y_reg;
            end
            default:
            begin
                ofs_x = '0;
                ofs_y = '0;
            end
        endcase
        if (info.neg)
        begin
            sum_x = SUM_W'(base.x) - SUM_W'(ofs_x);
            sum_y = SUM_W'(base.y) - SUM_W'(ofs_y);
        end
        else
        begin
            sum_x = SUM_W'(base.x) + SUM_W'(ofs_x);
            sum_y = SUM_W'(base.y) + SUM_W'(ofs_y);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_point_reg.x <= sat_coord(sum_x);
            out_point_reg.y <= sat_coord(sum_y);
            out_start_reg   <= info.start;
            out_stop_reg    <= info.stop;
            out_last_reg    <= info.fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_point = out_point_reg;
    assign out_start = out_start_reg;
    assign out_stop  = out_stop_reg;
    assign out_last  = out_last_reg;

endmodule

// File: sv/polyline_to_bezier_controls.sv
// top level: polyline points in, cubic bezier control points out
// depends on pbc_pkg, pbc_front, pbc_queue, pbc_back
//
//  channel  | direction | data                          | tuser               | tlast
//  ---------+-----------+-------------------------------+---------------------+-----------
//  s_axis   | in        | point_x [23:0], point_y [47:24]| -                   | last_point
//  m_axis   | out       | ctrl_x [23:0], ctrl_y [47:24] | curve_start, curve_end | point_last
//  cfg      | in        | tangent_scale [15:0]          | -                   | -
//
// a point is taken in any cycle the four-entry job queue has room; each point gives
// zero to five results, delivered one per cycle when the output is not stalled, through a
// registered output, so the sustained rate is set by the output port.
// results pass the multiply, round and output register stages in that order.
// reset clears control state only; no clearing pass. either side may stall freely.
module polyline_to_bezier_controls (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pbc_pkg::TDATA_W-1:0]     s_axis_tdata,   // point_x, point_y
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pbc_pkg::TDATA_W-1:0]     m_axis_tdata,   // ctrl_x, ctrl_y
    output logic [pbc_pkg::TUSER_W-1:0]     m_axis_tuser,   // curve_start, curve_end
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbc_pkg::SCALE_W-1:0]     cfg_data
);
    import pbc_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    point_t             in_point;
    point_t             out_point;
    job_t               push_job;
    job_t               pop_job;
    logic               push;
    logic               queue_full;
    logic               pop_valid;
    logic               pop;
    logic               out_start;
    logic               out_stop;

    // tangent scale register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            scale_reg <= cfg_data;
        end
    end

    assign in_point.x = s_axis_tdata[COORD_W-1:0];
    assign in_point.y = s_axis_tdata[TDATA_W-1:COORD_W];

    pbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_point   (in_point),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    pbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_job   (pop_job)
    );

    pbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (scale_reg),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_point (out_point),
        .out_start (out_start),
        .out_stop  (out_stop),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_point.y, out_point.x};
    assign m_axis_tuser = {out_stop, out_start};

endmodule
